// File: sv/gcv_pkg.sv
`default_nettype none

package gcv_pkg;

    // Default depths of the two delay lines.
    localparam int MAX_ARCH_LAGS  = 4;
    localparam int MAX_GARCH_LAGS = 4;

    // Coefficient slots held in each packed 64-bit register.
    localparam int COEFF_SLOTS = 4;
    localparam int COEFF_W     = 16;

    localparam int VAR_W      = 32;
    localparam int RESID_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ORDER_W    = 3;
    localparam int DATES_W    = 3;
    localparam int LAG_W      = 3;
    localparam int LAG_IDX_W  = 2;
    localparam int PROD_W     = COEFF_W + VAR_W;
    localparam int ACC_W      = PROD_W + 5;

    localparam logic [DATES_W-1:0] DATES_MAX = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONSTANT     = 3'd0,
        CFG_ARCH_ORDER   = 3'd1,
        CFG_GARCH_ORDER  = 3'd2,
        CFG_ARCH_COEFFS  = 3'd3,
        CFG_GARCH_COEFFS = 3'd4
    } gcv_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARCH,
        ST_GARCH,
        ST_FLUSH,
        ST_FINISH
    } gcv_state_t;

    typedef struct packed {
        logic                      series_start;
        logic signed [RESID_W-1:0] prev_residual;
    } gcv_in_t;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic             saturated;
    } gcv_out_t;

    typedef struct packed {
        logic                 load;
        logic                 mac;
        logic                 mac_garch;
        logic [LAG_IDX_W-1:0] lag_idx;
        logic                 finish;
    } gcv_cmd_t;

    typedef struct packed {
        logic [LAG_W-1:0] arch_lags;
        logic [LAG_W-1:0] garch_lags;
        logic             out_busy;
    } gcv_status_t;

endpackage

`default_nettype wire

// File: sv/gcv_stream_if.sv
`default_nettype none

interface gcv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/gcv_controller.sv
`default_nettype none

module gcv_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gcv_pkg::gcv_status_t status,
    output gcv_pkg::gcv_cmd_t        cmd
);

    gcv_pkg::gcv_state_t         state_reg, state_next;
    logic [gcv_pkg::LAG_W-1:0]   cnt_reg, cnt_next;
    logic [gcv_pkg::LAG_W-1:0]   cnt_inc;

    assign cnt_inc = cnt_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcv_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            gcv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = gcv_pkg::ST_ARCH;
                end
            end
            gcv_pkg::ST_ARCH:
            begin
                if (cnt_reg < status.arch_lags)
                begin
                    cmd.mac     = 1'b1;
                    cmd.lag_idx = cnt_reg[gcv_pkg::LAG_IDX_W-1:0];
                end
                if (cnt_inc >= status.arch_lags)
                begin
                    cnt_next   = '0;
                    state_next = gcv_pkg::ST_GARCH;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            gcv_pkg::ST_GARCH:
            begin
                if (cnt_reg < status.garch_lags)
                begin
                    cmd.mac       = 1'b1;
                    cmd.mac_garch = 1'b1;
                    cmd.lag_idx   = cnt_reg[gcv_pkg::LAG_IDX_W-1:0];
                end
                if (cnt_inc >= status.garch_lags)
                begin
                    cnt_next   = '0;
                    state_next = gcv_pkg::ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            gcv_pkg::ST_FLUSH:
            begin
                state_next = gcv_pkg::ST_FINISH;
            end
            gcv_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = gcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gcv_pkg::ST_IDLE;
            end
        endcase
    end

    // A residual lag is only issued below the current residual lag limit.
    a_arch_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac && !cmd.mac_garch) |-> ({1'b0, cmd.lag_idx} < status.arch_lags))
        else $error("residual lag issued beyond its limit");

    // A variance lag is only issued below the current variance lag limit.
    a_garch_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac && cmd.mac_garch) |-> ({1'b0, cmd.lag_idx} < status.garch_lags))
        else $error("variance lag issued beyond its limit");

    // An accepted request always opens the residual lag pass.
    a_load_to_arch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == gcv_pkg::ST_ARCH))
        else $error("accepted request did not start the lag pass");

    // The product pipeline is drained before the next request can load.
    a_mac_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac |=> !cmd.load)
        else $error("request loaded while a product was in flight");

endmodule

`default_nettype wire

// File: sv/gcv_datapath.sv
`default_nettype none

module gcv_datapath #(
    parameter int MAX_ARCH_LAGS  = gcv_pkg::MAX_ARCH_LAGS,
    parameter int MAX_GARCH_LAGS = gcv_pkg::MAX_GARCH_LAGS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gcv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gcv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire gcv_pkg::gcv_in_t                   sample_data,
    input  wire gcv_pkg::gcv_cmd_t                  cmd,
    output gcv_pkg::gcv_status_t                    status,
    gcv_stream_if.source                            result
);

    localparam int A_USE = (MAX_ARCH_LAGS < gcv_pkg::COEFF_SLOTS) ?
                           MAX_ARCH_LAGS : gcv_pkg::COEFF_SLOTS;
    localparam int G_USE = (MAX_GARCH_LAGS < gcv_pkg::COEFF_SLOTS) ?
                           MAX_GARCH_LAGS : gcv_pkg::COEFF_SLOTS;

    logic [gcv_pkg::VAR_W-1:0]      const_reg;
    logic [gcv_pkg::ORDER_W-1:0]    arch_order_reg;
    logic [gcv_pkg::ORDER_W-1:0]    garch_order_reg;
    logic [gcv_pkg::CFG_DATA_W-1:0] arch_coeffs_reg;
    logic [gcv_pkg::CFG_DATA_W-1:0] garch_coeffs_reg;

    logic [gcv_pkg::VAR_W-1:0]      sqr_line_reg [MAX_ARCH_LAGS];
    logic [gcv_pkg::VAR_W-1:0]      var_line_reg [MAX_GARCH_LAGS];
    logic [gcv_pkg::DATES_W-1:0]    dates_reg;

    logic [gcv_pkg::ACC_W-1:0]      acc_reg;
    logic [gcv_pkg::PROD_W-1:0]     prod_reg;
    logic                           prod_vld_reg;

    logic                           out_valid_reg;
    logic [gcv_pkg::VAR_W-1:0]      out_var_reg;
    logic                           out_sat_reg;

    logic [gcv_pkg::RESID_W-1:0]    resid_raw;
    logic [gcv_pkg::RESID_W-1:0]    resid_mag;
    logic [2*gcv_pkg::RESID_W-1:0]  resid_sq;
    logic [gcv_pkg::VAR_W-1:0]      line_sel;
    logic [gcv_pkg::COEFF_W-1:0]    coeff_sel;
    logic                           sum_sat;
    logic [gcv_pkg::VAR_W-1:0]      h_val;

    function automatic logic [gcv_pkg::LAG_W-1:0] lag_limit(
        input logic [gcv_pkg::ORDER_W-1:0] order,
        input logic [gcv_pkg::DATES_W-1:0] dates,
        input int                          depth
    );
        logic [gcv_pkg::LAG_W-1:0] n;
        n = order;
        if (int'(n) > depth)
            n = gcv_pkg::LAG_W'(depth);
        if (n > dates)
            n = dates;
        return n;
    endfunction

    // The magnitude of the most negative residual wraps to itself, which is exact.
    assign resid_raw = sample_data.prev_residual;
    assign resid_mag = resid_raw[gcv_pkg::RESID_W-1] ? (~resid_raw + 24'd1) : resid_raw;
    assign resid_sq  = resid_mag * resid_mag;

    always_comb
    begin
        line_sel  = '0;
        coeff_sel = '0;
        if (cmd.mac_garch)
        begin
            for (int k = 0; k < G_USE; k++)
                if (cmd.lag_idx == gcv_pkg::LAG_IDX_W'(k))
                    line_sel = var_line_reg[k];
            for (int k = 0; k < gcv_pkg::COEFF_SLOTS; k++)
                if (cmd.lag_idx == gcv_pkg::LAG_IDX_W'(k))
                    coeff_sel = garch_coeffs_reg[gcv_pkg::COEFF_W*k +: gcv_pkg::COEFF_W];
        end
        else
        begin
            for (int k = 0; k < A_USE; k++)
                if (cmd.lag_idx == gcv_pkg::LAG_IDX_W'(k))
                    line_sel = sqr_line_reg[k];
            for (int k = 0; k < gcv_pkg::COEFF_SLOTS; k++)
                if (cmd.lag_idx == gcv_pkg::LAG_IDX_W'(k))
                    coeff_sel = arch_coeffs_reg[gcv_pkg::COEFF_W*k +: gcv_pkg::COEFF_W];
        end
    end

    assign sum_sat = |acc_reg[gcv_pkg::ACC_W-1:gcv_pkg::PROD_W];
    assign h_val   = sum_sat ? '1 : acc_reg[gcv_pkg::PROD_W-1:gcv_pkg::COEFF_W];

    assign status.arch_lags  = lag_limit(arch_order_reg, dates_reg, A_USE);
    assign status.garch_lags = lag_limit(garch_order_reg, dates_reg, G_USE);
    assign status.out_busy   = out_valid_reg && !result.ready;

    assign result.valid            = out_valid_reg;
    assign result.payload.variance = out_var_reg;
    assign result.payload.saturated = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_reg        <= '0;
            arch_order_reg   <= '0;
            garch_order_reg  <= '0;
            arch_coeffs_reg  <= '0;
            garch_coeffs_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcv_pkg::CFG_CONSTANT:     const_reg        <= cfg_wdata[gcv_pkg::VAR_W-1:0];
                gcv_pkg::CFG_ARCH_ORDER:   arch_order_reg   <= cfg_wdata[gcv_pkg::ORDER_W-1:0];
                gcv_pkg::CFG_GARCH_ORDER:  garch_order_reg  <= cfg_wdata[gcv_pkg::ORDER_W-1:0];
                gcv_pkg::CFG_ARCH_COEFFS:  arch_coeffs_reg  <= cfg_wdata;
                gcv_pkg::CFG_GARCH_COEFFS: garch_coeffs_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ARCH_LAGS; k++)
                sqr_line_reg[k] <= '0;
            dates_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (sample_data.series_start)
            begin
                for (int k = 0; k < MAX_ARCH_LAGS; k++)
                    sqr_line_reg[k] <= '0;
                dates_reg <= '0;
            end
            else
            begin
                for (int k = MAX_ARCH_LAGS - 1; k > 0; k--)
                    sqr_line_reg[k] <= sqr_line_reg[k-1];
                sqr_line_reg[0] <= resid_sq[gcv_pkg::VAR_W+gcv_pkg::COEFF_W-1:gcv_pkg::COEFF_W];
                if (dates_reg != gcv_pkg::DATES_MAX)
                    dates_reg <= dates_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_GARCH_LAGS; k++)
                var_line_reg[k] <= '0;
        end
        else if (cmd.load && sample_data.series_start)
        begin
            for (int k = 0; k < MAX_GARCH_LAGS; k++)
                var_line_reg[k] <= '0;
        end
        else if (cmd.finish)
        begin
            for (int k = MAX_GARCH_LAGS - 1; k > 0; k--)
                var_line_reg[k] <= var_line_reg[k-1];
            var_line_reg[0] <= h_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= cmd.mac;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coeff_sel * line_sel;
        if (cmd.load)
            acc_reg <= {{(gcv_pkg::ACC_W-gcv_pkg::PROD_W){1'b0}}, const_reg,
                        {gcv_pkg::COEFF_W{1'b0}}};
        else if (prod_vld_reg)
            acc_reg <= acc_reg + gcv_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_var_reg <= h_val;
            out_sat_reg <= sum_sat;
        end
    end

endmodule

`default_nettype wire

// File: sv/garch_conditional_variance.sv
`default_nettype none

// Channel   Direction  Payload                               Handshake
// sample    in         series_start, prev_residual (Q8.16)   valid / ready
// result    out        variance (Q16.16), saturated          valid / ready
// cfg       in         cfg_index, cfg_wdata                  cfg_we, no wait
//
// A request is taken in the idle state, then the shared multiplier walks the
// active residual lags and then the active variance lags (each pass runs even
// with no active lag), followed by a drain state and a write-back state; the
// next request is taken only after the write-back returns to idle.
// Reset clears the configuration, both delay lines and the date count.
// A result held in the output register does not block the next request; only
// the write-back cycle waits while the previous result has not been taken.

module garch_conditional_variance #(
    parameter int MAX_ARCH_LAGS  = gcv_pkg::MAX_ARCH_LAGS,
    parameter int MAX_GARCH_LAGS = gcv_pkg::MAX_GARCH_LAGS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gcv_stream_if.sink                          sample,
    gcv_stream_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [gcv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Commands from the sequencer and status back from the datapath are the
    // only connection between the two halves.
    gcv_pkg::gcv_cmd_t    cmd;
    gcv_pkg::gcv_status_t status;

    // The sequencer walks the residual lags first, then the variance lags,
    // issuing one multiply-accumulate per cycle on the shared unit.
    gcv_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the configuration registers, both delay lines, the
    // squarer, the product register, the accumulator and the output register.
    gcv_datapath #(
        .MAX_ARCH_LAGS  (MAX_ARCH_LAGS),
        .MAX_GARCH_LAGS (MAX_GARCH_LAGS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .sample_data (sample.payload),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

endmodule

`default_nettype wire
